@@ design/pid_controller_antiwindup_assert.svh @@
// Assertion macros shared by the PID controller RTL.
// Included by the modules that carry concurrent checks; needs no package.
`ifndef PID_CONTROLLER_ANTIWINDUP_ASSERT_SVH
`define PID_CONTROLLER_ANTIWINDUP_ASSERT_SVH

// Checked on every rising edge while reset is released.
`define PIDAW_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication shorthand: antecedent holds, consequent holds on the next edge.
`define PIDAW_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/pidaw_pkg.sv @@
// Shared types and constants for the PID controller with integral clamp.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package pidaw_pkg;

  // Queue between front and back
  localparam int unsigned FifoDepth = 4;
  localparam int unsigned FifoAw    = $clog2(FifoDepth);
  localparam int unsigned FifoCw    = $clog2(FifoDepth + 1);

  // Fixed-point widths
  localparam int unsigned ErrW    = 17;  // setpoint minus measurement
  localparam int unsigned SumW    = 32;  // clamped error sum
  localparam int unsigned StenW   = 20;  // -3e0 + 4e1 - e2
  localparam int unsigned PW      = 33;  // prop_gain * e0
  localparam int unsigned IW      = 48;  // int_gain * sum
  localparam int unsigned DW      = 36;  // deriv_gain * stencil
  localparam int unsigned TotW    = 51;  // 2P + 2I + D, 23 fraction bits
  localparam int unsigned RndSh   = 9;   // Q.23 down to Q.14
  localparam int unsigned LimW    = 31;
  localparam int unsigned CfgDataW = 31;

  localparam logic signed [TotW-1:0] OneQ23  = TotW'(64'sd8388608);
  localparam logic signed [TotW-1:0] HalfLsb = TotW'(64'sd256);
  localparam logic signed [15:0]     OneQ14  = 16'sd16384;

  // Configuration register indexes
  typedef enum logic [1:0] {
    RegPropGain     = 2'd0,
    RegIntGain      = 2'd1,
    RegDerivGain    = 2'd2,
    RegIntegralLim  = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic signed [15:0] prop_gain;
    logic signed [15:0] int_gain;
    logic signed [15:0] deriv_gain;
    logic [LimW-1:0]    integral_limit;
  } cfg_t;

  typedef struct packed {
    logic signed [15:0] target_value;
    logic signed [15:0] measured_value;
  } in_beat_t;

  typedef struct packed {
    logic signed [15:0] drive;
    logic               drive_clipped;
  } out_beat_t;

  // Work item handed from front to back
  typedef struct packed {
    logic signed [ErrW-1:0]  err;
    logic signed [SumW-1:0]  sum;
    logic signed [StenW-1:0] stencil;
  } work_t;

endpackage

@@ design/pidaw_front.sv @@
// Front end: takes input beats, forms the error, the clamped error sum and
// the derivative stencil, and pushes one work item per beat. Uses pidaw_pkg.
`timescale 1ns / 1ps

module pidaw_front import pidaw_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  in_beat_t        in_data_i,
  input  logic [LimW-1:0] limit_i,
  input  logic            q_full_i,
  output logic            q_push_o,
  output work_t           q_data_o
);

  logic signed [ErrW-1:0]  err_last_q, err_last_d;
  logic signed [ErrW-1:0]  err_prev_q, err_prev_d;
  logic signed [SumW-1:0]  err_sum_q, err_sum_d;

  logic signed [ErrW-1:0]  e0;
  logic signed [SumW+1:0]  sum_raw, lim_pos, lim_neg, sum_clamp;
  logic signed [StenW-1:0] e0x, e1x, e2x, stencil;
  logic                    push;

  assign in_stall_o = q_full_i;
  assign push       = in_valid_i && !q_full_i;

  // Error, exact in 17 bits
  assign e0 = {in_data_i.target_value[15], in_data_i.target_value}
            - {in_data_i.measured_value[15], in_data_i.measured_value};

  // Integral sum with clamp to +-limit
  always_comb begin
    sum_raw   = {{2{err_sum_q[SumW-1]}}, err_sum_q}
              + {{(SumW+2-ErrW){e0[ErrW-1]}}, e0};
    lim_pos   = {3'b000, limit_i};
    lim_neg   = -lim_pos;
    sum_clamp = sum_raw;
    if (sum_raw > lim_pos) begin
      sum_clamp = lim_pos;
    end
    if (sum_clamp < lim_neg) begin
      sum_clamp = lim_neg;
    end
  end

  // Derivative stencil -3e0 + 4e1 - e2
  assign e0x     = {{(StenW-ErrW){e0[ErrW-1]}}, e0};
  assign e1x     = {{(StenW-ErrW){err_last_q[ErrW-1]}}, err_last_q};
  assign e2x     = {{(StenW-ErrW){err_prev_q[ErrW-1]}}, err_prev_q};
  assign stencil = (e1x <<< 2) - (e0x + (e0x <<< 1)) - e2x;

  always_comb begin
    err_last_d = err_last_q;
    err_prev_d = err_prev_q;
    err_sum_d  = err_sum_q;
    if (push) begin
      err_last_d = e0;
      err_prev_d = err_last_q;
      err_sum_d  = sum_clamp[SumW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      err_last_q <= '0;
      err_prev_q <= '0;
      err_sum_q  <= '0;
    end else begin
      err_last_q <= err_last_d;
      err_prev_q <= err_prev_d;
      err_sum_q  <= err_sum_d;
    end
  end

  assign q_push_o         = push;
  assign q_data_o.err     = e0;
  assign q_data_o.sum     = sum_clamp[SumW-1:0];
  assign q_data_o.stencil = stencil;

endmodule

@@ design/pidaw_fifo.sv @@
// Short work queue between front and back ends.
// Uses pidaw_pkg for the entry type and depth; includes the assertion macros.
`timescale 1ns / 1ps
`include "pid_controller_antiwindup_assert.svh"

module pidaw_fifo import pidaw_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  work_t push_data_i,
  output logic  full_o,
  output logic  valid_o,
  input  logic  pop_i,
  output work_t pop_data_o
);

  work_t              mem_q [FifoDepth];
  logic [FifoAw-1:0]  wr_ptr_q, wr_ptr_d;
  logic [FifoAw-1:0]  rd_ptr_q, rd_ptr_d;
  logic [FifoCw-1:0]  count_q, count_d;

  assign full_o     = (count_q == FifoCw'(FifoDepth));
  assign valid_o    = (count_q != '0);
  assign pop_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == FifoAw'(FifoDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == FifoAw'(FifoDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage, no reset
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  `PIDAW_ASSERT(a_fifo_bound, clk_i, rst_ni, count_q <= FifoCw'(FifoDepth), "fifo overfilled")
  `PIDAW_ASSERT(a_fifo_pop_nonempty, clk_i, rst_ni, !pop_i || valid_o, "pop from empty fifo")
  `PIDAW_ASSERT_NEXT(a_fifo_grow, clk_i, rst_ni, push_i && !pop_i, count_q == $past(count_q) + 1'b1, "fifo count did not grow on push")

endmodule

@@ design/pidaw_back.sv @@
// Back end: three gain multiplies, the Q.23 total, then clip and rounding
// into the output register. Uses pidaw_pkg; includes the assertion macros.
`timescale 1ns / 1ps
`include "pid_controller_antiwindup_assert.svh"

module pidaw_back import pidaw_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cfg_t      cfg_i,
  input  logic      q_valid_i,
  output logic      q_pop_o,
  input  work_t     q_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_beat_t out_data_o
);

  // Stage valids
  logic v1_q, v1_d, v2_q, v2_d, v3_q, v3_d;
  logic out_free, s2_free, s1_free;

  // Stage payloads
  logic signed [PW-1:0]   p_q;
  logic signed [IW-1:0]   i_q;
  logic signed [DW-1:0]   d_q;
  logic signed [TotW-1:0] tot_q, tot_d;
  out_beat_t              out_q, out_d;

  logic signed [PW-1:0]   p_d;
  logic signed [IW-1:0]   i_d;
  logic signed [DW-1:0]   d_d;
  logic signed [TotW-1:0] rnd;

  // Pipeline advance: a stage takes a new beat when it is empty or drains
  assign out_free = !v3_q || !out_stall_i;
  assign s2_free  = !v2_q || out_free;
  assign s1_free  = !v1_q || s2_free;
  assign q_pop_o  = q_valid_i && s1_free;

  assign v1_d = s1_free  ? q_pop_o : v1_q;
  assign v2_d = s2_free  ? v1_q    : v2_q;
  assign v3_d = out_free ? v2_q    : v3_q;

  // Stage 1: gain products
  assign p_d = PW'(cfg_i.prop_gain) * PW'(q_data_i.err);
  assign i_d = IW'(cfg_i.int_gain) * IW'(q_data_i.sum);
  assign d_d = DW'(cfg_i.deriv_gain) * DW'(q_data_i.stencil);

  // Stage 2: total in Q.23, 2P + 2I + D
  assign tot_d = (TotW'(p_q) <<< 1) + (TotW'(i_q) <<< 1) + TotW'(d_q);

  // Stage 3: clip to +-1.0, else round half up to Q.14
  assign rnd = (tot_q + HalfLsb) >>> RndSh;
  always_comb begin
    out_d.drive         = rnd[15:0];
    out_d.drive_clipped = 1'b0;
    if (tot_q > OneQ23) begin
      out_d.drive         = OneQ14;
      out_d.drive_clipped = 1'b1;
    end else if (tot_q < -OneQ23) begin
      out_d.drive         = -OneQ14;
      out_d.drive_clipped = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= v1_d;
      v2_q <= v2_d;
      v3_q <= v3_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_free) begin
      p_q <= p_d;
      i_q <= i_d;
      d_q <= d_d;
    end
    if (s2_free) begin
      tot_q <= tot_d;
    end
    if (out_free) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = v3_q;
  assign out_data_o  = out_q;

  `PIDAW_ASSERT(a_back_range, clk_i, rst_ni, !v3_q || (out_q.drive <= OneQ14 && out_q.drive >= -OneQ14), "drive beyond +-1.0")
  `PIDAW_ASSERT(a_back_clip_rail, clk_i, rst_ni, !(v3_q && out_q.drive_clipped) || out_q.drive == OneQ14 || out_q.drive == -OneQ14, "clipped beat not at rail")
  `PIDAW_ASSERT_NEXT(a_back_hold, clk_i, rst_ni, v3_q && out_stall_i, v3_q && out_q == $past(out_q), "stalled result lost")

endmodule

@@ design/pid_controller_antiwindup.sv @@
// PID controller with integral clamp: top level, configuration registers
// and the front/queue/back instances. Uses pidaw_pkg.
//
// Usage:
//   Input beats (target_value, measured_value, signed Q2.14) arrive on
//   in_valid_i / in_stall_o / in_data_i; one result beat (drive in Q2.14,
//   drive_clipped) leaves per input on out_valid_o / out_stall_i / out_data_o.
//   A beat moves when valid is high and stall is low.
//   Gains and the integral limit are written through cfg_we_i, cfg_index_i,
//   cfg_wdata_i, by the user only while no beat is in flight; not enforced.
// Timing:
//   One beat per cycle sustained while out_stall_i is low. A result passes
//   in order: the accepting edge updates the error history and clamped sum
//   and writes the 4-entry queue, then come the multiply stage, the total
//   stage and the clip/round output register.
// Reset:
//   Gains go to 0, the limit to 2^31-1, error history and sum to 0, queue
//   and pipeline empty. No clearing pass; input is taken right after reset.
// Stall:
//   The back pipeline fills and then holds while out_stall_i is high; the
//   queue then fills and in_stall_o rises when it is full. Nothing is dropped.
`timescale 1ns / 1ps

module pid_controller_antiwindup import pidaw_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  in_beat_t            in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output out_beat_t           out_data_o
);

  cfg_t  cfg_q, cfg_d;
  logic  q_push, q_full, q_valid, q_pop;
  work_t q_wdata, q_rdata;

  // Configuration register writes
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_index_i))
        RegPropGain:    cfg_d.prop_gain      = cfg_wdata_i[15:0];
        RegIntGain:     cfg_d.int_gain       = cfg_wdata_i[15:0];
        RegDerivGain:   cfg_d.deriv_gain     = cfg_wdata_i[15:0];
        RegIntegralLim: cfg_d.integral_limit = cfg_wdata_i[LimW-1:0];
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.prop_gain      <= '0;
      cfg_q.int_gain       <= '0;
      cfg_q.deriv_gain     <= '0;
      cfg_q.integral_limit <= '1;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  pidaw_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .limit_i    (cfg_q.integral_limit),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_data_o   (q_wdata)
  );

  pidaw_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_wdata),
    .full_o      (q_full),
    .valid_o     (q_valid),
    .pop_i       (q_pop),
    .pop_data_o  (q_rdata)
  );

  pidaw_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_valid_i   (q_valid),
    .q_pop_o     (q_pop),
    .q_data_i    (q_rdata),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule
